### sv/hsvc_pkg.sv
`default_nettype none

package hsvc_pkg;

    // Pixel classes
    typedef logic [1:0] pixel_class_t;
    localparam pixel_class_t CLASS_RED     = 2'd0;
    localparam pixel_class_t CLASS_NEUTRAL = 2'd1;
    localparam pixel_class_t CLASS_DARK    = 2'd2;

    // Which channel holds the maximum (priority red, green, blue)
    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } hue_sector_t;

    // Register indexes on the APB port (word addresses)
    localparam int unsigned ADDR_W = 5;
    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_MODE           = 3'd0;
    localparam reg_idx_t REG_RED_HUE_NARROW = 3'd1;
    localparam reg_idx_t REG_RED_HUE_WIDE   = 3'd2;
    localparam reg_idx_t REG_SAT_RED_MIN    = 3'd3;
    localparam reg_idx_t REG_SAT_LOW_MAX    = 3'd4;
    localparam reg_idx_t REG_VAL_DARK_LIMIT = 3'd5;

    // Register reset values
    localparam logic       MODE_RST           = 1'b0;
    localparam logic [7:0] RED_HUE_NARROW_RST = 8'd40;
    localparam logic [7:0] RED_HUE_WIDE_RST   = 8'd60;
    localparam logic [7:0] SAT_RED_MIN_RST    = 8'd100;
    localparam logic [7:0] SAT_LOW_MAX_RST    = 8'd40;
    localparam logic [7:0] VAL_DARK_LIMIT_RST = 8'd50;

    // Hue constants in degrees, saturation scale and channel maximum
    localparam logic [15:0] HUE_SLOPE   = 16'd60;
    localparam logic [15:0] HUE_OFS_G   = 16'd120;
    localparam logic [15:0] HUE_OFS_B   = 16'd240;
    localparam logic [7:0]  HUE_UPPER   = 8'd180;
    localparam logic [7:0]  HUE_NEUTRAL = 8'd140;
    localparam logic [7:0]  THR_HUE_RED = 8'd30;
    localparam logic [7:0]  THR_HUE_MID = 8'd50;
    localparam logic [15:0] SAT_SCALE   = 16'd255;
    localparam logic [7:0]  CH_MAX      = 8'd255;

    // Pipeline depth from request acceptance to result strobe
    localparam int unsigned LATENCY = 4;

endpackage

`default_nettype wire

### sv/hsv_pixel_color_classifier.sv
`default_nettype none

// HSV pixel color classifier. Takes one 8-bit RGB pixel per request and
// returns one result: a class (red piece, neutral background, dark piece)
// and the recolored pixel (255,0,0 / 255,255,255 / 0,0,0). A request is
// taken every clock cycle; busy is always low. The result sits on the
// result ports for exactly one cycle, marked by done, once the request
// has passed the registered stages (stage 1 max/min/sector, stage 2 hue
// and saturation fractions, stage 3 threshold products, stage 4 compare
// and classify). The receiver cannot stall the pipeline, so it must take
// every done pulse. Thresholds must be written over the APB port only
// while no request is in flight; the block itself does not enforce this.
// Register i sits at byte address 4*i, unknown addresses are ignored on
// write and read as zero.
module hsv_pixel_color_classifier
    import hsvc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Request channel
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [7:0]        red,
    input  wire logic [7:0]        green,
    input  wire logic [7:0]        blue,
    // Result channel
    output logic                   done,
    output logic [1:0]             pixel_class,
    output logic [7:0]             out_red,
    output logic [7:0]             out_green,
    output logic [7:0]             out_blue,
    // APB configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic       mode_reg;
    logic [7:0] red_hue_narrow_reg;
    logic [7:0] red_hue_wide_reg;
    logic [7:0] sat_red_min_reg;
    logic [7:0] sat_low_max_reg;
    logic [7:0] val_dark_limit_reg;

    logic     cfg_wr;
    reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= MODE_RST;
            red_hue_narrow_reg <= RED_HUE_NARROW_RST;
            red_hue_wide_reg   <= RED_HUE_WIDE_RST;
            sat_red_min_reg    <= SAT_RED_MIN_RST;
            sat_low_max_reg    <= SAT_LOW_MAX_RST;
            val_dark_limit_reg <= VAL_DARK_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_MODE:           mode_reg           <= pwdata[0];
                REG_RED_HUE_NARROW: red_hue_narrow_reg <= pwdata[7:0];
                REG_RED_HUE_WIDE:   red_hue_wide_reg   <= pwdata[7:0];
                REG_SAT_RED_MIN:    sat_red_min_reg    <= pwdata[7:0];
                REG_SAT_LOW_MAX:    sat_low_max_reg    <= pwdata[7:0];
                REG_VAL_DARK_LIMIT: val_dark_limit_reg <= pwdata[7:0];
                default:            ;  // drop writes to unmapped addresses
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_MODE:           prdata = {31'd0, mode_reg};
            REG_RED_HUE_NARROW: prdata = {24'd0, red_hue_narrow_reg};
            REG_RED_HUE_WIDE:   prdata = {24'd0, red_hue_wide_reg};
            REG_SAT_RED_MIN:    prdata = {24'd0, sat_red_min_reg};
            REG_SAT_LOW_MAX:    prdata = {24'd0, sat_low_max_reg};
            REG_VAL_DARK_LIMIT: prdata = {24'd0, val_dark_limit_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // The pipeline never stalls: every request is taken.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: max, min, delta, hue sector and the sector's channel
    // difference. Valid bits ride alongside the payload.
    // ------------------------------------------------------------------
    logic              s1_valid_reg;
    logic [7:0]        s1_max_reg, s1_max_next;
    logic [7:0]        s1_delta_reg, s1_delta_next;
    hue_sector_t       s1_sect_reg, s1_sect_next;
    logic signed [8:0] s1_diff_reg, s1_diff_next;

    logic [7:0] mx, mn;

    always_comb
    begin
        mx = red;
        if (green > mx) mx = green;
        if (blue > mx)  mx = blue;
        mn = red;
        if (green < mn) mn = green;
        if (blue < mn)  mn = blue;

        s1_max_next   = mx;
        s1_delta_next = mx - mn;

        // Tied maxima resolve red first, then green, then blue.
        priority if (red == mx)
        begin
            s1_sect_next = SECT_RED;
            s1_diff_next = $signed({1'b0, green}) - $signed({1'b0, blue});
        end
        else if (green == mx)
        begin
            s1_sect_next = SECT_GREEN;
            s1_diff_next = $signed({1'b0, blue}) - $signed({1'b0, red});
        end
        else
        begin
            s1_sect_next = SECT_BLUE;
            s1_diff_next = $signed({1'b0, red}) - $signed({1'b0, green});
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: hue = hnum/hden, saturation = snum/sden, value
    // ------------------------------------------------------------------
    logic               s2_valid_reg;
    logic signed [17:0] s2_hnum_reg, s2_hnum_next;
    logic [7:0]         s2_hden_reg, s2_hden_next;
    logic [15:0]        s2_snum_reg, s2_snum_next;
    logic [7:0]         s2_sden_reg, s2_sden_next;
    logic [7:0]         s2_val_reg;

    logic signed [17:0] diff_x;
    logic [15:0]        hue_ofs;

    always_comb
    begin
        diff_x = {{9{s1_diff_reg[8]}}, s1_diff_reg};
        unique case (s1_sect_reg)
            SECT_RED:   hue_ofs = 16'd0;
            SECT_GREEN: hue_ofs = {8'd0, s1_delta_reg} * HUE_OFS_G;
            SECT_BLUE:  hue_ofs = {8'd0, s1_delta_reg} * HUE_OFS_B;
            default:    hue_ofs = 16'd0;
        endcase
        // Grey pixels have a zero difference, so hnum is zero there too.
        s2_hnum_next = diff_x * $signed({2'b00, HUE_SLOPE}) + $signed({2'b00, hue_ofs});
        s2_hden_next = (s1_delta_reg == 8'd0) ? 8'd1 : s1_delta_reg;
        s2_snum_next = {8'd0, s1_delta_reg} * SAT_SCALE;
        s2_sden_next = (s1_max_reg == 8'd0) ? 8'd1 : s1_max_reg;
    end

    // ------------------------------------------------------------------
    // Stage 3: scale every hue and saturation threshold by its fraction's denominator
    // ------------------------------------------------------------------
    logic               s3_valid_reg;
    logic signed [17:0] s3_hnum_reg;
    logic [15:0]        s3_snum_reg;
    logic [7:0]         s3_val_reg;
    logic [15:0]        s3_h_narrow_reg, s3_h_wide_reg, s3_h_upper_reg, s3_h_neutral_reg;
    logic [15:0]        s3_h_red_reg, s3_h_mid_reg;
    logic [15:0]        s3_s_red_reg, s3_s_low_reg;

    // ------------------------------------------------------------------
    // Stage 4: compare and classify
    // ------------------------------------------------------------------
    logic         done_reg;
    pixel_class_t class_reg, class_next;

    logic signed [17:0] p_narrow, p_wide, p_upper, p_neutral, p_red, p_mid;
    logic hue_gt_upper, hue_gt_neutral, hue_in_narrow, hue_in_wide;
    logic hue_lt_red, hue_lt_mid, sat_red, sat_low, val_gt, val_lt;

    always_comb
    begin
        p_narrow  = $signed({2'b00, s3_h_narrow_reg});
        p_wide    = $signed({2'b00, s3_h_wide_reg});
        p_upper   = $signed({2'b00, s3_h_upper_reg});
        p_neutral = $signed({2'b00, s3_h_neutral_reg});
        p_red     = $signed({2'b00, s3_h_red_reg});
        p_mid     = $signed({2'b00, s3_h_mid_reg});

        hue_gt_upper   = s3_hnum_reg > p_upper;
        hue_gt_neutral = s3_hnum_reg > p_neutral;
        hue_in_narrow  = (s3_hnum_reg <= p_narrow) && (s3_hnum_reg >= -p_narrow);
        hue_in_wide    = (s3_hnum_reg <= p_wide) && (s3_hnum_reg >= -p_wide);
        hue_lt_red     = s3_hnum_reg < p_red;
        hue_lt_mid     = s3_hnum_reg < p_mid;
        sat_red        = s3_snum_reg > s3_s_red_reg;
        sat_low        = s3_snum_reg < s3_s_low_reg;
        val_gt         = s3_val_reg > val_dark_limit_reg;
        val_lt         = s3_val_reg < val_dark_limit_reg;

        if (mode_reg)
        begin
            // Simple hue threshold variant
            priority if (hue_lt_red)
                class_next = CLASS_RED;
            else if (hue_lt_mid)
                class_next = val_gt ? CLASS_RED : CLASS_DARK;
            else
                class_next = CLASS_DARK;
        end
        else
        begin
            // Full HSV rule set, first match wins
            priority if (hue_gt_upper)
                class_next = sat_low ? CLASS_NEUTRAL : CLASS_DARK;
            else if (hue_gt_neutral)
                class_next = CLASS_NEUTRAL;
            else if (hue_in_narrow)
                class_next = sat_red ? CLASS_RED : CLASS_NEUTRAL;
            else if (hue_in_wide)
            begin
                if (val_gt)
                    class_next = sat_red ? CLASS_RED : CLASS_NEUTRAL;
                else
                    class_next = CLASS_DARK;
            end
            else
                class_next = val_lt ? CLASS_DARK : CLASS_NEUTRAL;
        end
    end

    // Valid bits: reset clears the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg;
        end
    end

    // Payload: advance every cycle, no reset needed.
    always_ff @(posedge clk)
    begin
        s1_max_reg   <= s1_max_next;
        s1_delta_reg <= s1_delta_next;
        s1_sect_reg  <= s1_sect_next;
        s1_diff_reg  <= s1_diff_next;

        s2_hnum_reg <= s2_hnum_next;
        s2_hden_reg <= s2_hden_next;
        s2_snum_reg <= s2_snum_next;
        s2_sden_reg <= s2_sden_next;
        s2_val_reg  <= s1_max_reg;

        s3_hnum_reg      <= s2_hnum_reg;
        s3_snum_reg      <= s2_snum_reg;
        s3_val_reg       <= s2_val_reg;
        s3_h_narrow_reg  <= {8'd0, s2_hden_reg} * {8'd0, red_hue_narrow_reg};
        s3_h_wide_reg    <= {8'd0, s2_hden_reg} * {8'd0, red_hue_wide_reg};
        s3_h_upper_reg   <= {8'd0, s2_hden_reg} * {8'd0, HUE_UPPER};
        s3_h_neutral_reg <= {8'd0, s2_hden_reg} * {8'd0, HUE_NEUTRAL};
        s3_h_red_reg     <= {8'd0, s2_hden_reg} * {8'd0, THR_HUE_RED};
        s3_h_mid_reg     <= {8'd0, s2_hden_reg} * {8'd0, THR_HUE_MID};
        s3_s_red_reg     <= {8'd0, s2_sden_reg} * {8'd0, sat_red_min_reg};
        s3_s_low_reg     <= {8'd0, s2_sden_reg} * {8'd0, sat_low_max_reg};

        class_reg <= class_next;
    end

    // Result ports: recolor straight from the registered class.
    assign done        = done_reg;
    assign pixel_class = class_reg;
    assign out_red     = (class_reg == CLASS_DARK)    ? 8'd0   : CH_MAX;
    assign out_green   = (class_reg == CLASS_NEUTRAL) ? CH_MAX : 8'd0;
    assign out_blue    = (class_reg == CLASS_NEUTRAL) ? CH_MAX : 8'd0;

endmodule

`default_nettype wire

### sv/hsvc_checker.sv
`default_nettype none

module hsvc_checker
    import hsvc_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              done,
    input wire logic [1:0]        pixel_class,
    input wire logic [7:0]        out_red,
    input wire logic [7:0]        out_green,
    input wire logic [7:0]        out_blue
);

    // Every request yields a result once it has passed the pipeline.
    a_req_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("request not answered after pipeline latency");

    // No result without a matching request.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##4 !done)
        else $error("result strobe without a request");

    // A result carries a legal class.
    a_class_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pixel_class == CLASS_RED || pixel_class == CLASS_NEUTRAL ||
                  pixel_class == CLASS_DARK))
        else $error("illegal pixel class");

    // The recolored pixel agrees with the class.
    a_recolor: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((pixel_class == CLASS_RED && out_red == CH_MAX &&
                   out_green == 8'd0 && out_blue == 8'd0) ||
                  (pixel_class == CLASS_NEUTRAL && out_red == CH_MAX &&
                   out_green == CH_MAX && out_blue == CH_MAX) ||
                  (pixel_class == CLASS_DARK && out_red == 8'd0 &&
                   out_green == 8'd0 && out_blue == 8'd0)))
        else $error("recolored pixel does not match class");

endmodule

bind hsv_pixel_color_classifier hsvc_checker u_hsvc_checker (.*);

`default_nettype wire

### test/hsv_result_checker.sv
`default_nettype none

module hsv_result_checker
    import hsvc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire logic [7:0]        red,
    input  wire logic [7:0]        green,
    input  wire logic [7:0]        blue,
    input  wire logic              done,
    input  wire logic [1:0]        pixel_class,
    input  wire logic [7:0]        out_red,
    input  wire logic [7:0]        out_green,
    input  wire logic [7:0]        out_blue,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    input  wire logic [31:0]       prdata,
    input  wire logic              pready,
    output int                     errors,
    output int                     pending,
    output int                     results
);

    localparam int SECTOR_G_OFS = 120;
    localparam int SECTOR_B_OFS = 240;
    localparam int DEG_PER_SECT = 60;
    localparam int SAT_FULL     = 255;
    localparam int HUE_TOP      = 180;
    localparam int HUE_PALE     = 140;
    localparam int THR_RED      = 30;
    localparam int THR_MID      = 50;

    typedef struct packed {
        pixel_class_t cls;
        logic [7:0]   r;
        logic [7:0]   g;
        logic [7:0]   b;
    } recolor_t;

    recolor_t   expected_px[$];
    logic       cfg_mode;
    logic [7:0] cfg_narrow;
    logic [7:0] cfg_wide;
    logic [7:0] cfg_sat_red_min;
    logic [7:0] cfg_sat_low_max;
    logic [7:0] cfg_val_dark;
    int         err_cnt;
    int         checked;

    // Hue and saturation stay as fractions; every hue and saturation threshold test is cross-multiplied.
    function automatic pixel_class_t classify_pixel(input logic [7:0] r8, g8, b8);
        int r, g, b, mx, mn, d, hn, hd, sn, sd;
        int nar, wid, srm, slm, vdl;
        logic red_sat;
        r = int'(r8);
        g = int'(g8);
        b = int'(b8);
        nar = int'(cfg_narrow);
        wid = int'(cfg_wide);
        srm = int'(cfg_sat_red_min);
        slm = int'(cfg_sat_low_max);
        vdl = int'(cfg_val_dark);
        mx = (g > r) ? g : r;
        mx = (b > mx) ? b : mx;
        mn = (g < r) ? g : r;
        mn = (b < mn) ? b : mn;
        d = mx - mn;
        if (d == 0) begin
            hn = 0;
            hd = 1;
        end else begin
            hd = d;
            if (r == mx)
                hn = DEG_PER_SECT * (g - b);
            else if (g == mx)
                hn = DEG_PER_SECT * (b - r) + SECTOR_G_OFS * d;
            else
                hn = DEG_PER_SECT * (r - g) + SECTOR_B_OFS * d;
        end
        if (mx == 0) begin
            sn = 0;
            sd = 1;
        end else begin
            sn = SAT_FULL * d;
            sd = mx;
        end
        red_sat = sn > srm * sd;
        if (cfg_mode) begin
            if (hn < THR_RED * hd)
                return CLASS_RED;
            if (hn < THR_MID * hd)
                return (mx > vdl) ? CLASS_RED : CLASS_DARK;
            return CLASS_DARK;
        end
        if (hn > HUE_TOP * hd)
            return (sn < slm * sd) ? CLASS_NEUTRAL : CLASS_DARK;
        if (hn > HUE_PALE * hd)
            return CLASS_NEUTRAL;
        if (hn <= nar * hd && hn >= -nar * hd)
            return red_sat ? CLASS_RED : CLASS_NEUTRAL;
        if (hn <= wid * hd && hn >= -wid * hd) begin
            if (mx > vdl)
                return red_sat ? CLASS_RED : CLASS_NEUTRAL;
            return CLASS_DARK;
        end
        return (mx < vdl) ? CLASS_DARK : CLASS_NEUTRAL;
    endfunction

    function automatic logic [31:0] reg_value(input reg_idx_t idx);
        case (idx)
            REG_MODE:           return {31'b0, cfg_mode};
            REG_RED_HUE_NARROW: return {24'b0, cfg_narrow};
            REG_RED_HUE_WIDE:   return {24'b0, cfg_wide};
            REG_SAT_RED_MIN:    return {24'b0, cfg_sat_red_min};
            REG_SAT_LOW_MAX:    return {24'b0, cfg_sat_low_max};
            REG_VAL_DARK_LIMIT: return {24'b0, cfg_val_dark};
            default:            return 32'b0;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
        if (act !== exp) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, act);
            err_cnt++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        recolor_t     want;
        pixel_class_t cls;
        reg_idx_t     idx;
        if (!rst_n) begin
            cfg_mode        = MODE_RST;
            cfg_narrow      = RED_HUE_NARROW_RST;
            cfg_wide        = RED_HUE_WIDE_RST;
            cfg_sat_red_min = SAT_RED_MIN_RST;
            cfg_sat_low_max = SAT_LOW_MAX_RST;
            cfg_val_dark    = VAL_DARK_LIMIT_RST;
            expected_px.delete();
            err_cnt = 0;
            checked = 0;
            errors  <= 0;
            pending <= 0;
            results <= 0;
        end else begin
            if (done === 1'b1) begin
                if (expected_px.size() == 0) begin
                    $display("%0t: result with no request pending, class %0d rgb %0d,%0d,%0d",
                             $time, pixel_class, out_red, out_green, out_blue);
                    err_cnt++;
                end else begin
                    want = expected_px.pop_front();
                    check_field("pixel_class", 32'(want.cls), 32'(pixel_class));
                    check_field("out_red", 32'(want.r), 32'(out_red));
                    check_field("out_green", 32'(want.g), 32'(out_green));
                    check_field("out_blue", 32'(want.b), 32'(out_blue));
                    checked++;
                end
            end
            if (start && !busy) begin
                cls = classify_pixel(red, green, blue);
                want.cls = cls;
                want.r   = (cls == CLASS_DARK) ? 8'd0 : 8'd255;
                want.g   = (cls == CLASS_NEUTRAL) ? 8'd255 : 8'd0;
                want.b   = (cls == CLASS_NEUTRAL) ? 8'd255 : 8'd0;
                expected_px.insert(expected_px.size(), want);
            end
            idx = paddr[ADDR_W-1:2];
            if (psel && penable && pready && !pwrite)
                check_field("prdata", reg_value(idx), prdata);
            if (psel && penable && pready && pwrite) begin
                case (idx)
                    REG_MODE:           cfg_mode        = pwdata[0];
                    REG_RED_HUE_NARROW: cfg_narrow      = pwdata[7:0];
                    REG_RED_HUE_WIDE:   cfg_wide        = pwdata[7:0];
                    REG_SAT_RED_MIN:    cfg_sat_red_min = pwdata[7:0];
                    REG_SAT_LOW_MAX:    cfg_sat_low_max = pwdata[7:0];
                    REG_VAL_DARK_LIMIT: cfg_val_dark    = pwdata[7:0];
                    default: ;
                endcase
            end
            errors  <= err_cnt;
            pending <= expected_px.size();
            results <= checked;
        end
    end

endmodule

`default_nettype wire

### test/tb_hsv_pixel_color_classifier.sv
`default_nettype none

module tb_hsv_pixel_color_classifier;
    import hsvc_pkg::*;

    // Register slots past the last mapped one; writes must be dropped, reads give zero.
    localparam reg_idx_t REG_SPARE_LO = 3'd6;
    localparam reg_idx_t REG_SPARE_HI = 3'd7;
    localparam int       NUM_PLANS    = 9;
    localparam int       PX_PER_PLAN  = 62;
    localparam int       NUM_CORNER   = 25;

    logic              clk     = 1'b0;
    logic              rst_n   = 1'b0;
    logic              start   = 1'b0;
    logic [7:0]        red     = 8'd0;
    logic [7:0]        green   = 8'd0;
    logic [7:0]        blue    = 8'd0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [31:0]       pwdata  = 32'd0;

    logic              busy;
    logic              done;
    logic [1:0]        pixel_class;
    logic [7:0]        out_red;
    logic [7:0]        out_green;
    logic [7:0]        out_blue;
    logic [31:0]       prdata;
    logic              pready;

    int                errors;
    int                pending;
    int                results;

    // Register values of the current plan, in register order.
    logic [7:0]        cfg_set [6];
    logic [23:0]       corner_px [NUM_CORNER];
    int                pixels_sent = 0;
    int                plans_run   = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    hsv_pixel_color_classifier u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .done        (done),
        .pixel_class (pixel_class),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Watch both channels, predict every request and compare every result.
    hsv_result_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .done        (done),
        .pixel_class (pixel_class),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .errors      (errors),
        .pending     (pending),
        .results     (results)
    );

    // One APB transfer: setup cycle, then access cycle until pready.
    // Leave psel high so back-to-back transfers never drop and raise it in one step.
    task automatic apb_access(input reg_idx_t idx, input logic wr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    // Close a burst of transfers and return the bus to idle.
    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Read every slot, mapped or not; the checker compares prdata.
    task automatic read_all_regs();
        for (int i = 0; i < 8; i++)
            apb_access(reg_idx_t'(i), 1'b0, 32'd0);
    endtask

    // Write the plan, hit the unmapped slots with junk, then read it all back.
    // Fill the unused upper bits with noise so masking on write is exercised.
    task automatic program_config();
        logic [31:0] d;
        for (int i = 0; i < 8; i++) begin
            d = $urandom;
            if (reg_idx_t'(i) == REG_MODE)
                d[0] = cfg_set[i][0];
            else if (reg_idx_t'(i) != REG_SPARE_LO && reg_idx_t'(i) != REG_SPARE_HI)
                d[7:0] = cfg_set[i];
            apb_access(reg_idx_t'(i), 1'b1, d);
        end
        read_all_regs();
        apb_release();
    endtask

    // Offer one pixel request and hold it until taken.
    // Then, while the drawn odds say so, idle the sender: drop
    // start and toss noise onto the pixel lines while idle.
    task automatic send_pixel(input logic [7:0] r, g, b, input int gap_pct);
        start <= 1'b1;
        red   <= r;
        green <= g;
        blue  <= b;
        do @(posedge clk); while (busy);
        pixels_sent++;
        while ($urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            red   <= 8'($urandom);
            green <= 8'($urandom);
            blue  <= 8'($urandom);
            @(posedge clk);
        end
    endtask

    // Pause the sender until every predicted result has come back, then
    // let the pipeline settle before touching the registers.
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // Random pixels, mostly shaped to land on the hue and saturation edges.
    task automatic run_plan(input int n, input int gap_pct);
        logic [7:0] r, g, b;
        int         mn, k, d;
        for (int i = 0; i < n; i++) begin
            mn = $urandom_range(0, 195);
            k  = $urandom_range(0, 60);
            case ($urandom_range(0, 8))
                0, 1: begin
                    r = 8'($urandom);
                    g = 8'($urandom);
                    b = 8'($urandom);
                end
                2: begin
                    // grey: all channels equal
                    r = 8'($urandom);
                    g = r;
                    b = r;
                end
                3: begin
                    // red max, hue 0..60 in whole degrees
                    b = 8'(mn);
                    r = 8'(mn + 60);
                    g = 8'(mn + k);
                end
                4: begin
                    // red max, hue -60..0
                    g = 8'(mn);
                    r = 8'(mn + 60);
                    b = 8'(mn + k);
                end
                5: begin
                    // tied maximum or minimum between two channels
                    r = 8'($urandom);
                    g = 8'($urandom);
                    b = 8'($urandom);
                    case ($urandom_range(0, 2))
                        0: g = r;
                        1: b = r;
                        default: b = g;
                    endcase
                end
                6: begin
                    // dark corner near the value limit
                    r = 8'($urandom_range(0, 63));
                    g = 8'($urandom_range(0, 63));
                    b = 8'($urandom_range(0, 63));
                end
                7: begin
                    // green or blue max, hue 120..300 around 140 and 180
                    r = 8'(mn);
                    g = 8'(mn);
                    b = 8'(mn);
                    case ($urandom_range(0, 2))
                        0: begin g = 8'(mn + 60); b = 8'(mn + k); end
                        1: begin b = 8'(mn + 60); g = 8'(mn + k); end
                        default: begin b = 8'(mn + 60); r = 8'(mn + k); end
                    endcase
                end
                default: begin
                    // max 255 so saturation equals the spread: sit on a threshold
                    d = $urandom_range(0, 1) ? int'(cfg_set[REG_SAT_RED_MIN])
                                             : int'(cfg_set[REG_SAT_LOW_MAX]);
                    d = d + int'($urandom_range(0, 2)) - 1;
                    d = (d < 0) ? 0 : (d > 255) ? 255 : d;
                    if ($urandom_range(0, 1)) begin
                        r = 8'd255;
                        g = 8'(255 - d);
                        b = 8'(255 - d);
                    end else begin
                        b = 8'd255;
                        r = 8'(255 - d);
                        g = 8'(255 - d);
                    end
                end
            endcase
            send_pixel(r, g, b, gap_pct);
        end
    endtask

    initial begin
        int gap;
        corner_px = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
                      24'hFFFF00, 24'hFF00FF, 24'h00FFFF, 24'h808080, 24'h010000,
                      24'h000001, 24'hFFFEFE, 24'h0A0000, 24'h320000, 24'h330000,
                      24'hFF9B9B, 24'hFF9C9C, 24'h3C1E00, 24'h3C2800, 24'h3C3200,
                      24'h003C14, 24'h003C3C, 24'h003C3D, 24'h1E1E20, 24'h3C0028};

        // Hold reset at the start, once, then release it.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values must read back before anything is written.
        read_all_regs();
        apb_release();

        // Corner pixels under the reset thresholds: black, white, primaries,
        // tied maxima, grey, and pixels right on the hue, value and
        // saturation edges.
        foreach (corner_px[j])
            send_pixel(corner_px[j][23:16], corner_px[j][15:8], corner_px[j][7:0], 11);
        drain();

        for (int p = 0; p < NUM_PLANS; p++) begin
            // Register plans, columns: mode, narrow, wide, sat_red_min,
            // sat_low_max, val_dark_limit.
            case (p)
                0: cfg_set = '{8'd0, 8'd40,  8'd60,  8'd100, 8'd40,  8'd50};
                1: cfg_set = '{8'd0, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0};
                2: cfg_set = '{8'd0, 8'd0,   8'd180, 8'd255, 8'd255, 8'd255};
                3: cfg_set = '{8'd0, 8'd255, 8'd200, 8'd128, 8'd200, 8'd1};
                4: cfg_set = '{8'd1, 8'd40,  8'd60,  8'd100, 8'd40,  8'd50};
                5: cfg_set = '{8'd1, 8'd200, 8'd20,  8'd0,   8'd255, 8'd0};
                6: cfg_set = '{8'd1, 8'd0,   8'd0,   8'd255, 8'd0,   8'd255};
                default: begin
                    cfg_set[REG_MODE] = {7'd0, 1'($urandom)};
                    for (int i = 1; i < 6; i++)
                        cfg_set[i] = 8'($urandom);
                end
            endcase
            // Sender gaps: rare first, then frequent, then none (back-to-back).
            gap = (p < 3) ? 11 : (p < 6) ? 54 : 0;
            program_config();
            run_plan(PX_PER_PLAN, gap);
            drain();
            plans_run++;
        end

        repeat (LATENCY + 4) @(posedge clk);
        $display("summary: %0d pixel requests under %0d register plans, %0d results compared",
                 pixels_sent, plans_run + 1, results);
        $display("summary: both modes, threshold extremes, readback and unmapped slots covered");
        if (errors == 0)
            $display("tb_hsv_pixel_color_classifier: done, clean");
        else
            $display("tb_hsv_pixel_color_classifier: done, errors");
        $finish;
    end

    // Stop a hung run.
    initial begin
        #400000;
        $display("tb_hsv_pixel_color_classifier: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
sv/hsvc_pkg.sv
sv/hsv_pixel_color_classifier.sv
sv/hsvc_checker.sv
test/hsv_result_checker.sv
test/tb_hsv_pixel_color_classifier.sv
